FILE: rtl/tpfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpfe_pkg: shared types and constants of the tap peak feature extractor
// Field widths, reset values, axis codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package tpfe_pkg;

    // Default capture limit; the top level hands it down as a parameter.
    localparam int MAX_SAMPLES_DEF = 512;

    // Fixed field widths of the stream words.
    localparam int AXIS_W    = 16;
    localparam int SUM_W     = AXIS_W + 1;
    localparam int PIDX_W    = 9;
    localparam int DOM_W     = 2;
    localparam int PCT_W     = 7;
    localparam int LEN_W     = 10;
    localparam int S_DATA_W  = 48;
    localparam int M_FIELD_W = 3 * AXIS_W + PIDX_W + DOM_W + PCT_W + LEN_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // Percent scaling and the divider operand width.
    localparam int              PCT_SCALE_W = 7;
    localparam logic [PCT_SCALE_W-1:0] PCT_SCALE = 7'd100;
    localparam int              DIVD_W      = SUM_W + PCT_SCALE_W;

    // Reset value of the minimum capture length register.
    localparam logic [LEN_W-1:0] MIN_SAMPLES_RST = 10'd100;

    // Dominant axis codes.
    localparam logic [DOM_W-1:0] AXIS_X = 2'd0;
    localparam logic [DOM_W-1:0] AXIS_Y = 2'd1;
    localparam logic [DOM_W-1:0] AXIS_Z = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_PREP,
        ST_DIV,
        ST_HOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic div_start;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_fire;
        logic div_done;
        logic out_free;
    } t_sts;

    // Magnitude of a signed 16-bit sample; the most negative value maps to 2^15.
    function automatic logic [SUM_W-1:0] f_mag(input logic [AXIS_W-1:0] v);
        logic [SUM_W-1:0] ext;
        ext = {1'b0, v};
        return v[AXIS_W-1] ? (SUM_W'(1) << AXIS_W) - ext : ext;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tap_peak_feature_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: words that do not end a capture are taken one per cycle, back to back.
// A word with tlast drops tready while the controller runs a setup state, seven divider
// steps for the Z share (one quotient bit each), a state that sees done and one that loads
// the result, which then shows tvalid; a word still held at the output delays the load
// and keeps tready low until that word is taken.
// Reset is synchronous, active low: it clears the capture state and sets min_samples to 100.
// ----------------------------------------------------------------------------
// tap_peak_feature_extractor: peak L1 magnitude feature extractor
// Finds the sample with the largest |x|+|y|+|z| in each capture and emits
// its axes, index, dominant axis, Z share and the capture length.
// ----------------------------------------------------------------------------
module tap_peak_feature_extractor
    import tpfe_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [LEN_W-1:0]    i_cfg_wdata,    // min_samples
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                i_s_axis_tlast, // last_sample
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // peak_x [15:0], peak_y [31:16], peak_z [47:32], peak_index [56:48],
    // major_axis [58:57], z_share_pct [65:59], capture_length [75:66], zero pad
    output logic [M_DATA_W-1:0]      o_m_axis_tdata,
    output logic                     o_m_axis_tuser  // too_short
);

    t_cmd cmd;
    t_sts sts;

    tpfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tpfe_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tlast   (i_s_axis_tlast),
        .i_m_tready  (i_m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser)
    );

    assign o_s_axis_tready = cmd.in_ready;

    // The end of a capture always starts the division in the next cycle.
    a_last_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.last_fire |=> cmd.div_start)
        else $error("capture end did not start the division");

    // No word is accepted while the divider is finishing.
    a_no_accept_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.div_done |-> !cmd.in_ready)
        else $error("input accepted while the divider completes");

    // A load always presents a result word in the next cycle.
    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_m_axis_tvalid)
        else $error("result load did not raise tvalid");

    // A result is loaded only when the output register is free.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result loaded over a pending word");

endmodule
`default_nettype wire

FILE: rtl/tpfe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpfe_div: restoring divider for the Z share
// Produces one quotient bit per cycle, most significant first. The quotient
// is known to stay below 2^PCT_W, so only PCT_W steps are needed.
// ----------------------------------------------------------------------------
module tpfe_div
    import tpfe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [SUM_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [PCT_W-1:0]       o_quot
);

    localparam int STEP_W = $clog2(PCT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIVD_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_divisor;
    logic [PCT_W-1:0]  r_quot;

    logic [DIVD_W-1:0] shifted;
    logic              fits;

    // Trial subtraction of the divisor aligned to the current quotient bit.
    always_comb begin
        shifted = DIVD_W'(r_divisor) << r_step;
        fits    = (r_rem >= shifted);
    end

    // Control: busy flag, step counter and a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(PCT_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_dividend;
            r_divisor <= i_divisor;
            r_quot    <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - shifted;
            end
            r_quot <= {r_quot[PCT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

FILE: rtl/tpfe_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpfe_dp: datapath of the tap peak feature extractor
// Tracks the peak L1 magnitude sample of a capture, holds the finished
// capture's features, runs the Z share division and drives the output word.
// ----------------------------------------------------------------------------
module tpfe_dp
    import tpfe_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [LEN_W-1:0]    i_cfg_wdata,
    input  wire logic                i_s_tvalid,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire logic                i_s_tlast,
    input  wire logic                i_m_tready,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    output logic                     o_m_tvalid,
    output logic [M_DATA_W-1:0]      o_m_tdata,
    output logic                     o_m_tuser
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CMP_W = CNT_W + LEN_W;

    logic [LEN_W-1:0] r_min_samples;

    logic [SUM_W-1:0]  r_best_sum;
    logic [IDX_W-1:0]  r_best_idx;
    logic [AXIS_W-1:0] r_best_x, r_best_y, r_best_z;
    logic [CNT_W-1:0]  r_count;

    logic [AXIS_W-1:0] r_res_x, r_res_y, r_res_z;
    logic [PIDX_W-1:0] r_res_idx;
    logic [LEN_W-1:0]  r_res_len;
    logic              r_res_short;
    logic [DOM_W-1:0]  r_res_dom;
    logic              r_res_zero;

    logic              r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic              r_out_short;

    logic [AXIS_W-1:0] in_x, in_y, in_z;
    logic              fire;
    logic              in_range;
    logic [SUM_W-1:0]  in_sum;
    logic              better;
    logic [IDX_W-1:0]  n_best_idx;
    logic [AXIS_W-1:0] n_best_x, n_best_y, n_best_z;
    logic [CNT_W-1:0]  n_count;
    logic [IDX_W+PIDX_W-1:0] idx_ext;
    logic [CNT_W+LEN_W-1:0]  len_ext;
    logic              n_short;

    logic [SUM_W-1:0]  ax, ay, az, total;
    logic [DOM_W-1:0]  dom;
    logic [DIVD_W-1:0] dividend;
    logic              div_done;
    logic [PCT_W-1:0]  quot;
    logic [PCT_W-1:0]  share;

    // Unpack the input word.
    assign in_x = i_s_tdata[AXIS_W-1:0];
    assign in_y = i_s_tdata[2*AXIS_W-1:AXIS_W];
    assign in_z = i_s_tdata[3*AXIS_W-1:2*AXIS_W];
    assign fire = i_s_tvalid && i_cmd.in_ready;

    // Peak tracking: a strictly larger magnitude replaces the held sample.
    always_comb begin
        in_range   = (r_count < CNT_W'(MAX_SAMPLES));
        in_sum     = f_mag(in_x) + f_mag(in_y) + f_mag(in_z);
        better     = in_range && (in_sum > r_best_sum);
        n_best_idx = better ? r_count[IDX_W-1:0] : r_best_idx;
        n_best_x   = better ? in_x : r_best_x;
        n_best_y   = better ? in_y : r_best_y;
        n_best_z   = better ? in_z : r_best_z;
        n_count    = in_range ? r_count + 1'b1 : r_count;
        idx_ext    = {{PIDX_W{1'b0}}, n_best_idx};
        len_ext    = {{LEN_W{1'b0}}, n_count};
        n_short    = (CMP_W'(n_count) < CMP_W'(r_min_samples));
    end

    // Minimum capture length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_samples <= MIN_SAMPLES_RST;
        end else if (i_cfg_we) begin
            r_min_samples <= i_cfg_wdata;
        end
    end

    // Capture state; the last word of a capture clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_sum <= '0;
            r_best_idx <= '0;
            r_best_x   <= '0;
            r_best_y   <= '0;
            r_best_z   <= '0;
            r_count    <= '0;
        end else if (fire) begin
            if (i_s_tlast) begin
                r_best_sum <= '0;
                r_best_idx <= '0;
                r_best_x   <= '0;
                r_best_y   <= '0;
                r_best_z   <= '0;
                r_count    <= '0;
            end else begin
                r_best_sum <= better ? in_sum : r_best_sum;
                r_best_idx <= n_best_idx;
                r_best_x   <= n_best_x;
                r_best_y   <= n_best_y;
                r_best_z   <= n_best_z;
                r_count    <= n_count;
            end
        end
    end

    // Features of the finished capture, held while the share is computed.
    always_ff @(posedge i_clk) begin
        if (fire && i_s_tlast) begin
            r_res_x     <= n_best_x;
            r_res_y     <= n_best_y;
            r_res_z     <= n_best_z;
            r_res_idx   <= idx_ext[PIDX_W-1:0];
            r_res_len   <= len_ext[LEN_W-1:0];
            r_res_short <= n_short;
        end
    end

    // Magnitudes, dominant axis and divider operands of the held peak.
    always_comb begin
        ax    = f_mag(r_res_x);
        ay    = f_mag(r_res_y);
        az    = f_mag(r_res_z);
        total = ax + ay + az;
        if (az >= ax && az >= ay) begin
            dom = AXIS_Z;
        end else if (ax >= ay) begin
            dom = AXIS_X;
        end else begin
            dom = AXIS_Y;
        end
        dividend = DIVD_W'(az) * DIVD_W'(PCT_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_res_dom  <= dom;
            r_res_zero <= (total == '0);
        end
    end

    tpfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (total),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign share = r_res_zero ? '0 : quot;

    // Output register: loaded once per capture, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_short <= r_res_short;
            if (r_res_short) begin
                r_out_data <= M_DATA_W'({r_res_len, {(M_FIELD_W - LEN_W){1'b0}}});
            end else begin
                r_out_data <= M_DATA_W'({r_res_len, share, r_res_dom, r_res_idx,
                                         r_res_z, r_res_y, r_res_x});
            end
        end
    end

    // Status back to the controller.
    assign o_sts.last_fire = fire && i_s_tlast;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_short;

endmodule
`default_nettype wire

FILE: rtl/tpfe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpfe_ctrl: controller of the tap peak feature extractor
// Accepts words while scanning, then sequences the share division and the
// handoff of the result word to the output register.
// ----------------------------------------------------------------------------
module tpfe_ctrl
    import tpfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.last_fire) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

endmodule
`default_nettype wire
